[src/w3x3_pkg.sv]
package w3x3_pkg;

	localparam int PIX_W     = 8;
	localparam int POS_W     = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam int RESET_SIZE = 256;

	typedef logic [PIX_W-1:0] pix_t;

	// one column of the window, top row first
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} column_t;

	typedef struct packed {
		logic              emit;
		logic              frame_end;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic              clamp_w;
		logic              clamp_e;
		logic              clamp_n;
		logic              clamp_s;
	} win_ctrl_t;

	typedef struct packed {
		logic      work;
		logic      is_pix;
		win_ctrl_t win;
	} slot_t;

endpackage

[src/w3x3_pix_if.sv]
interface w3x3_pix_if import w3x3_pkg::*; ();

	logic valid;
	logic ready;
	pix_t pixel_value;
	logic fill;

	modport source(output valid, pixel_value, fill, input ready);
	modport sink(input valid, pixel_value, fill, output ready);

endinterface

[src/w3x3_win_if.sv]
interface w3x3_win_if import w3x3_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	pix_t             north_west;
	pix_t             north;
	pix_t             north_east;
	pix_t             west;
	pix_t             centre;
	pix_t             east;
	pix_t             south_west;
	pix_t             south;
	pix_t             south_east;
	logic             frame_end;

	modport source(
		output valid, pos_x, pos_y, north_west, north, north_east, west, centre, east,
			south_west, south, south_east, frame_end,
		input ready
	);
	modport sink(
		input valid, pos_x, pos_y, north_west, north, north_east, west, centre, east,
			south_west, south, south_east, frame_end,
		output ready
	);

endinterface

[src/w3x3_ram.sv]
module w3x3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/w3x3_col_cell.sv]
module w3x3_col_cell import w3x3_pkg::*; (
	input  logic    clk,
	input  logic    shift,
	input  column_t col_in,
	output column_t col_out
);

	column_t col_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

[src/w3x3_ctrl.sv]
module w3x3_ctrl import w3x3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic                 take,
	input  logic                 fill,
	output slot_t                slot,
	output logic [CW-1:0]        rd_addr
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int RESET_W = (RESET_SIZE < MAX_WIDTH) ? RESET_SIZE : MAX_WIDTH;
	localparam int RESET_H = (RESET_SIZE < MAX_HEIGHT) ? RESET_SIZE : MAX_HEIGHT;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [WW-1:0] in_col_q;
	logic [HW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;

	logic [WW-1:0] cfg_w;
	logic [HW-1:0] cfg_h;
	logic          cfg_hit;
	logic          is_drain;
	logic          work;
	logic          emit;
	logic          col_last;
	logic          at_e;
	logic          at_s;
	logic          last;

	// size registers hold the value already clamped to the supported range
	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_w = WW'(1);
		end else if (32'(cfg_wr_data) > 32'(MAX_WIDTH)) begin
			cfg_w = WW'(MAX_WIDTH);
		end else begin
			cfg_w = WW'(cfg_wr_data);
		end
		if (cfg_wr_data == '0) begin
			cfg_h = HW'(1);
		end else if (32'(cfg_wr_data) > 32'(MAX_HEIGHT)) begin
			cfg_h = HW'(MAX_HEIGHT);
		end else begin
			cfg_h = HW'(cfg_wr_data);
		end
	end

	assign cfg_hit  = cfg_wr_en && ((cfg_index == REG_FRAME_WIDTH) ||
		(cfg_index == REG_FRAME_HEIGHT));
	assign is_drain = (in_row_q == height_q);
	assign work     = take && (is_drain || !fill);
	assign col_last = (in_col_q == width_q - WW'(1));
	assign emit     = (in_row_q > HW'(1)) || ((in_row_q == HW'(1)) && (in_col_q != '0));
	assign at_e     = (WW'(out_col_q) == width_q - WW'(1));
	assign at_s     = (HW'(out_row_q) == height_q - HW'(1));
	assign last     = at_e && at_s;

	always_comb begin
		slot.work          = work;
		slot.is_pix        = !is_drain;
		slot.win.emit      = emit;
		slot.win.frame_end = last;
		slot.win.pos_x     = POS_W'(out_col_q);
		slot.win.pos_y     = POS_W'(out_row_q);
		slot.win.clamp_w   = (out_col_q == '0);
		slot.win.clamp_e   = at_e;
		slot.win.clamp_n   = (out_row_q == '0);
		slot.win.clamp_s   = at_s;
	end

	assign rd_addr = in_col_q[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WW'(RESET_W);
			height_q  <= HW'(RESET_H);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					width_q <= cfg_w;
				end
				REG_FRAME_HEIGHT: begin
					height_q <= cfg_h;
				end
				default: begin
				end
			endcase
			if (cfg_hit) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end
		end else if (work) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (!is_drain && col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + HW'(1);
				end else begin
					in_col_q <= in_col_q + WW'(1);
				end
				if (emit) begin
					if (at_e) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + RW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

endmodule

[src/window_3x3_clamped_edges.sv]
// 3x3 window generator with replicated frame borders
// pixel_in carries one grey pixel per request in raster order, or a fill
// request; window_out carries one 3x3 neighbourhood per request with the
// centre position and a last-of-frame mark. both use valid/ready.
// after the last pixel of a frame, send frame_width+1 fill requests to flush
// the final windows; fill requests sent while pixels are expected are dropped.
// throughput is one request per cycle while the receiver does not stall, set by
// the separate write and read ports of each line store and the one-column shift
// of the window cells per request. results run frame_width+1 requests behind
// the input; a result passes stages s1 and s2 before the output register.
// the cfg port writes frame_width (index 0) and frame_height (index 1); a write
// restarts the frame and must be made while the block is idle.
// reset restores a 256 x 256 frame (capped at the maximum size) and clears all
// position counters; the line stores are not cleared and need no clearing pass.
// when the receiver stalls, the output register holds its result and ready on
// pixel_in drops in the same cycle, freezing the whole pipeline.
module window_3x3_clamped_edges import w3x3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	w3x3_pix_if.sink             pixel_in,
	w3x3_win_if.source           window_out
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic          advance;
	logic          take;
	slot_t         slot;
	logic [CW-1:0] rd_addr;
	pix_t          up_rd;
	pix_t          mid_rd;
	logic          up_we;

	logic          valid_s1;
	logic          is_pix_s1;
	logic [CW-1:0] addr_s1;
	pix_t          pix_s1;
	win_ctrl_t     ctrl_s1;
	logic          valid_s2;
	win_ctrl_t     ctrl_s2;

	logic          byp_q;
	pix_t          byp_data_q;
	logic          out_valid_q;
	logic [POS_W-1:0] out_pos_x_q;
	logic [POS_W-1:0] out_pos_y_q;
	logic          out_end_q;
	column_t       out_wc_q;
	column_t       out_cc_q;
	column_t       out_ec_q;

	column_t       col_new;
	column_t       cell_w;
	column_t       cell_c;
	column_t       cell_e;
	column_t       wc_sel;
	column_t       ec_sel;
	column_t       wc_out;
	column_t       cc_out;
	column_t       ec_out;
	logic          shift;

	assign advance        = !out_valid_q || window_out.ready;
	assign pixel_in.ready = advance;
	assign take           = pixel_in.valid && advance;

	w3x3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.take        (take),
		.fill        (pixel_in.fill),
		.slot        (slot),
		.rd_addr     (rd_addr)
	);

	// middle line: written with the new pixel, read-first at the same address
	w3x3_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_mid_line (
		.clk     (clk),
		.wr_en   (slot.work && slot.is_pix),
		.wr_addr (rd_addr),
		.wr_data (pixel_in.pixel_value),
		.rd_en   (slot.work),
		.rd_addr (rd_addr),
		.rd_data (mid_rd)
	);

	// upper line: takes the old middle-line pixel read for the request in stage s1
	assign up_we = advance && valid_s1 && is_pix_s1;

	w3x3_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_up_line (
		.clk     (clk),
		.wr_en   (up_we),
		.wr_addr (addr_s1),
		.wr_data (mid_rd),
		.rd_en   (slot.work),
		.rd_addr (rd_addr),
		.rd_data (up_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			byp_q       <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1    <= slot.work;
				valid_s2    <= valid_s1;
				out_valid_q <= valid_s2 && ctrl_s2.emit;
			end
			// one-pixel-wide rows read the upper line while it is being written
			if (slot.work) begin
				byp_q <= up_we && (addr_s1 == rd_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot.work) begin
			byp_data_q <= mid_rd;
		end
		if (advance) begin
			is_pix_s1 <= slot.is_pix;
			addr_s1   <= rd_addr;
			pix_s1    <= pixel_in.pixel_value;
			ctrl_s1   <= slot.win;
			ctrl_s2   <= ctrl_s1;
			if (valid_s2 && ctrl_s2.emit) begin
				out_pos_x_q <= ctrl_s2.pos_x;
				out_pos_y_q <= ctrl_s2.pos_y;
				out_end_q   <= ctrl_s2.frame_end;
				out_wc_q    <= wc_out;
				out_cc_q    <= cc_out;
				out_ec_q    <= ec_out;
			end
		end
	end

	assign col_new = column_t'{
		top: byp_q ? byp_data_q : up_rd,
		mid: mid_rd,
		bot: pix_s1
	};
	assign shift = advance && valid_s1;

	w3x3_col_cell u_cell_e (
		.clk     (clk),
		.shift   (shift),
		.col_in  (col_new),
		.col_out (cell_e)
	);

	w3x3_col_cell u_cell_c (
		.clk     (clk),
		.shift   (shift),
		.col_in  (cell_e),
		.col_out (cell_c)
	);

	w3x3_col_cell u_cell_w (
		.clk     (clk),
		.shift   (shift),
		.col_in  (cell_c),
		.col_out (cell_w)
	);

	// edge replication: columns first, then rows
	always_comb begin
		wc_sel = ctrl_s2.clamp_w ? cell_c : cell_w;
		ec_sel = ctrl_s2.clamp_e ? cell_c : cell_e;

		wc_out     = wc_sel;
		wc_out.top = ctrl_s2.clamp_n ? wc_sel.mid : wc_sel.top;
		wc_out.bot = ctrl_s2.clamp_s ? wc_sel.mid : wc_sel.bot;
		cc_out     = cell_c;
		cc_out.top = ctrl_s2.clamp_n ? cell_c.mid : cell_c.top;
		cc_out.bot = ctrl_s2.clamp_s ? cell_c.mid : cell_c.bot;
		ec_out     = ec_sel;
		ec_out.top = ctrl_s2.clamp_n ? ec_sel.mid : ec_sel.top;
		ec_out.bot = ctrl_s2.clamp_s ? ec_sel.mid : ec_sel.bot;
	end

	assign window_out.valid      = out_valid_q;
	assign window_out.pos_x      = out_pos_x_q;
	assign window_out.pos_y      = out_pos_y_q;
	assign window_out.frame_end  = out_end_q;
	assign window_out.north_west = out_wc_q.top;
	assign window_out.west       = out_wc_q.mid;
	assign window_out.south_west = out_wc_q.bot;
	assign window_out.north      = out_cc_q.top;
	assign window_out.centre     = out_cc_q.mid;
	assign window_out.south      = out_cc_q.bot;
	assign window_out.north_east = out_ec_q.top;
	assign window_out.east       = out_ec_q.mid;
	assign window_out.south_east = out_ec_q.bot;

`ifndef SYNTH
	// the last window of a frame sits in the bottom-right corner
	a_end_corner: assert property (@(posedge clk) disable iff (!arst_n)
		window_out.valid && window_out.frame_end |->
			window_out.east == window_out.centre &&
			window_out.south == window_out.centre &&
			window_out.south_east == window_out.centre)
		else $error("frame end window is not clamped at the corner");

	// a frame end restarts positions at the origin
	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		window_out.valid && window_out.ready && window_out.frame_end |=>
			!window_out.valid || (window_out.pos_x == '0 && window_out.pos_y == '0))
		else $error("window after frame end does not start at the origin");
`endif

endmodule
